>>> rtl/assert_macros.svh
// Assertion macros for the checker file of the find/replace stream unit.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, idle while reset is asserted.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
	else $error("sfr: assertion failed");

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	`ASSERT_CLK(lbl, clk, rst_n, !(expr))

`endif

>>> rtl/sfr_pkg.sv
// Shared types, constants and helpers of the find/replace stream unit.
// Depends on nothing; imported by the interfaces and every module.
package sfr_pkg;

	localparam int BYTE_W   = 8;
	localparam int DATA_W   = 64;
	localparam int LEN_W    = 4;
	localparam int CNT_W    = 10;
	localparam int BIDX_W   = 3;
	localparam int ADDR_W   = 5;
	localparam int MAX_REPL = 8;

	// Register indexes, taken from paddr[4:3]
	localparam logic [1:0] REG_PATTERN_BYTES  = 2'd0;
	localparam logic [1:0] REG_PATTERN_LENGTH = 2'd1;
	localparam logic [1:0] REG_REPL_BYTES     = 2'd2;
	localparam logic [1:0] REG_REPL_LENGTH    = 2'd3;

	typedef struct packed {
		logic [DATA_W-1:0] pattern_bytes;
		logic [LEN_W-1:0]  pattern_length;
		logic [DATA_W-1:0] replacement_bytes;
		logic [LEN_W-1:0]  replacement_length;
	} sfr_cfg_t;

	// Pick byte i of a 64-bit text word, byte 0 in the low bits
	function automatic logic [BYTE_W-1:0] byte_at(input logic [DATA_W-1:0] w,
			input logic [BIDX_W-1:0] i);
		return w[{i, 3'b000} +: BYTE_W];
	endfunction

endpackage

>>> rtl/sfr_if.sv
// Stream channel interfaces of the find/replace stream unit: input and result items.
// Depends on sfr_pkg for field widths.
interface sfr_in_if import sfr_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] char_byte;
	logic              has_char;
	logic              line_end;

	modport source(output valid, char_byte, has_char, line_end, input ready);
	modport sink(input valid, char_byte, has_char, line_end, output ready);
	modport mon(input valid, ready, char_byte, has_char, line_end);
endinterface

interface sfr_out_if import sfr_pkg::*;;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              out_valid;
	logic              line_done;
	logic [CNT_W-1:0]  repl_count;
	logic              last_of_item;

	modport source(output valid, out_byte, out_valid, line_done, repl_count,
		last_of_item, input ready);
	modport sink(input valid, out_byte, out_valid, line_done, repl_count,
		last_of_item, output ready);
	modport mon(input valid, ready, out_byte, out_valid, line_done, repl_count,
		last_of_item);
endinterface

>>> rtl/sfr_cfg.sv
// APB-style register file holding pattern and replacement text and lengths.
// Depends on sfr_pkg for the register map and the configuration struct.
module sfr_cfg import sfr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output sfr_cfg_t          cfg
);

	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[ADDR_W-1:3];

	// Write the addressed register in the access cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_PATTERN_BYTES:  cfg.pattern_bytes      <= pwdata;
				REG_PATTERN_LENGTH: cfg.pattern_length     <= pwdata[LEN_W-1:0];
				REG_REPL_BYTES:     cfg.replacement_bytes  <= pwdata;
				REG_REPL_LENGTH:    cfg.replacement_length <= pwdata[LEN_W-1:0];
			endcase
		end
	end

	// Return the addressed register
	always_comb begin
		unique case (reg_idx)
			REG_PATTERN_BYTES:  prdata = cfg.pattern_bytes;
			REG_PATTERN_LENGTH: prdata = DATA_W'(cfg.pattern_length);
			REG_REPL_BYTES:     prdata = cfg.replacement_bytes;
			REG_REPL_LENGTH:    prdata = DATA_W'(cfg.replacement_length);
		endcase
	end

endmodule

>>> rtl/sfr_engine.sv
// Window, byte comparator and sequencer of the find/replace stream unit.
// Depends on sfr_pkg and the channel interfaces in sfr_if.sv.
module sfr_engine import sfr_pkg::*; #(
	parameter int MAX_PATTERN = 8,
	parameter int LINE_LIMIT  = 1024
) (
	input  logic      clk,
	input  logic      arst_n,
	input  sfr_cfg_t  cfg,
	sfr_in_if.sink    din,
	sfr_out_if.source dout
);

	localparam int DEPTH   = MAX_PATTERN;
	localparam int IW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FW      = $clog2(DEPTH + 1);
	localparam int CNT_MAX = (LINE_LIMIT - 1 < 1023) ? LINE_LIMIT - 1 : 1023;

	typedef enum logic [2:0] {
		S_IDLE, S_DECIDE, S_CMP, S_DROP, S_REPL, S_FLUSH, S_MARK
	} state_t;

	state_t             state_q;
	logic [BYTE_W-1:0]  win_q [DEPTH];
	logic [FW-1:0]      fill_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               has_q;
	logic               end_q;
	logic [LEN_W-1:0]   plen_q;
	logic [LEN_W-1:0]   rlen_q;
	logic [BIDX_W-1:0]  idx_q;
	logic               hit_q;

	logic               oval_q;
	logic [BYTE_W-1:0]  obyte_q;
	logic               ochar_q;
	logic               odone_q;
	logic [CNT_W-1:0]   ocnt_q;
	logic               olast_q;

	logic               accept;
	logic               out_free;
	logic [LEN_W-1:0]   fill4;
	logic [LEN_W-1:0]   plen_c;
	logic [LEN_W-1:0]   rlen_c;
	logic               byte_eq;
	logic               cmp_last;
	logic               win_load;
	logic               win_shift;
	logic               emit;
	logic [BYTE_W-1:0]  e_byte;
	logic               e_char;
	logic               e_last;
	logic               e_done;

	assign din.ready = (state_q == S_IDLE);
	assign accept    = din.valid && din.ready;
	assign out_free  = !oval_q || dout.ready;
	assign fill4     = LEN_W'(fill_q);
	assign win_load  = accept && din.has_char;

	// Clamp oversized lengths
	assign plen_c = (cfg.pattern_length > LEN_W'(MAX_PATTERN)) ?
		LEN_W'(MAX_PATTERN) : cfg.pattern_length;
	assign rlen_c = (cfg.replacement_length > LEN_W'(MAX_REPL)) ?
		LEN_W'(MAX_REPL) : cfg.replacement_length;

	// Shared byte comparator: one window byte against one pattern byte a cycle
	assign byte_eq  = (win_q[idx_q[IW-1:0]] == byte_at(cfg.pattern_bytes, idx_q));
	assign cmp_last = (LEN_W'(idx_q) == plen_q - LEN_W'(1));

	// Form the next result and decide whether it closes the item
	always_comb begin
		emit      = 1'b0;
		e_byte    = '0;
		e_char    = 1'b0;
		e_last    = 1'b0;
		e_done    = 1'b0;
		win_shift = 1'b0;
		unique case (state_q)
			S_DROP: begin
				emit      = out_free;
				e_byte    = win_q[0];
				e_char    = 1'b1;
				e_done    = end_q && (fill_q <= FW'(1));
				e_last    = !end_q || (fill_q <= FW'(1));
				win_shift = out_free;
			end
			S_REPL: begin
				emit   = out_free;
				e_byte = byte_at(cfg.replacement_bytes, idx_q);
				e_char = 1'b1;
				e_last = (LEN_W'(idx_q) == rlen_q - LEN_W'(1));
				e_done = e_last && end_q;
			end
			S_FLUSH: begin
				emit      = out_free;
				e_byte    = win_q[0];
				e_char    = 1'b1;
				e_last    = (fill_q == FW'(1));
				e_done    = e_last;
				win_shift = out_free;
			end
			S_MARK: begin
				emit   = out_free;
				e_last = 1'b1;
				e_done = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Window: load a new byte at the fill point, or shift out the oldest
	always_ff @(posedge clk) begin
		if (win_load) begin
			win_q[fill_q[IW-1:0]] <= din.char_byte;
		end else if (win_shift) begin
			for (int i = 0; i < DEPTH - 1; i++) begin
				win_q[i] <= win_q[i + 1];
			end
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q  <= '0;
			cnt_q   <= '0;
			has_q   <= 1'b0;
			end_q   <= 1'b0;
			plen_q  <= '0;
			rlen_q  <= '0;
			idx_q   <= '0;
			hit_q   <= 1'b0;
			oval_q  <= 1'b0;
			obyte_q <= '0;
			ochar_q <= 1'b0;
			odone_q <= 1'b0;
			ocnt_q  <= '0;
			olast_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						has_q   <= din.has_char;
						end_q   <= din.line_end;
						plen_q  <= plen_c;
						rlen_q  <= rlen_c;
						state_q <= S_DECIDE;
						if (din.has_char) begin
							fill_q <= fill_q + FW'(1);
						end
					end
				end
				S_DECIDE: begin
					priority if (!has_q) begin
						if (!end_q) begin
							state_q <= S_IDLE;
						end else begin
							state_q <= (fill_q != '0) ? S_FLUSH : S_MARK;
						end
					end else if (fill4 > plen_q || plen_q == '0) begin
						state_q <= S_DROP;
					end else if (fill4 == plen_q) begin
						idx_q   <= '0;
						hit_q   <= 1'b1;
						state_q <= S_CMP;
					end else begin
						state_q <= end_q ? S_FLUSH : S_IDLE;
					end
				end
				S_CMP: begin
					if (cmp_last) begin
						if (hit_q && byte_eq) begin
							fill_q <= '0;
							idx_q  <= '0;
							if (cnt_q < CNT_W'(CNT_MAX)) begin
								cnt_q <= cnt_q + CNT_W'(1);
							end
							priority if (rlen_q != '0) begin
								state_q <= S_REPL;
							end else if (end_q) begin
								state_q <= S_MARK;
							end else begin
								state_q <= S_IDLE;
							end
						end else begin
							state_q <= S_DROP;
						end
					end else begin
						hit_q <= hit_q && byte_eq;
						idx_q <= idx_q + BIDX_W'(1);
					end
				end
				S_DROP: begin
					if (emit) begin
						fill_q  <= fill_q - FW'(1);
						state_q <= e_last ? S_IDLE : S_FLUSH;
						if (e_done) begin
							cnt_q <= '0;
						end
					end
				end
				S_REPL: begin
					if (emit) begin
						idx_q <= idx_q + BIDX_W'(1);
						if (e_last) begin
							state_q <= S_IDLE;
							if (e_done) begin
								cnt_q <= '0;
							end
						end
					end
				end
				S_FLUSH: begin
					if (emit) begin
						fill_q <= fill_q - FW'(1);
						if (e_last) begin
							cnt_q   <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				S_MARK: begin
					if (emit) begin
						cnt_q   <= '0;
						state_q <= S_IDLE;
					end
				end
			endcase

			// Load a new result, or drop the held one once taken
			if (emit) begin
				oval_q  <= 1'b1;
				obyte_q <= e_byte;
				ochar_q <= e_char;
				odone_q <= e_done;
				ocnt_q  <= e_done ? cnt_q : '0;
				olast_q <= e_last;
			end else if (dout.ready) begin
				oval_q <= 1'b0;
			end
		end
	end

	assign dout.valid        = oval_q;
	assign dout.out_byte     = obyte_q;
	assign dout.out_valid    = ochar_q;
	assign dout.line_done    = odone_q;
	assign dout.repl_count   = ocnt_q;
	assign dout.last_of_item = olast_q;

endmodule

>>> rtl/string_find_replace_stream_unit.sv
// String find/replace stream unit: top level joining register file and engine.
// Depends on sfr_pkg, sfr_if.sv, sfr_cfg and sfr_engine.
//
// Usage: bytes of a text line enter on din (char_byte, has_char, line_end) with a
// valid/ready handshake. Results leave on dout, at most one byte per result, with
// last_of_item on the final result of each input item and line_done plus repl_count
// on the final result of a line. Pattern and replacement text and lengths are
// written through the APB-style port at byte addresses 0, 8, 16 and 24; the user
// must write them only while the unit is idle, as the block does not enforce it.
// Flow: an item is taken in the idle state, classified in the decide state, compared
// byte by byte when the window holds a full pattern of P bytes, and then emits its
// results. The comparator checks one byte per cycle and the single output register
// emits one result per cycle while the receiver takes them; din.ready is high only
// between items. A stalled receiver holds the current result in the output register
// and the sequencer waits; the next item may be taken while the last result still
// waits. Reset: all registers but the window storage clear to zero, the window is
// empty and the line count is zero; the unit is ready in the first cycle after reset.
module string_find_replace_stream_unit import sfr_pkg::*; #(
	parameter int MAX_PATTERN = 8,
	parameter int LINE_LIMIT  = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	sfr_in_if.sink            din,
	sfr_out_if.source         dout,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	sfr_cfg_t cfg;

	// Configuration registers
	sfr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// Search window, comparator and result sequencer
	sfr_engine #(
		.MAX_PATTERN (MAX_PATTERN),
		.LINE_LIMIT  (LINE_LIMIT)
	) u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.din    (din),
		.dout   (dout)
	);

endmodule

>>> rtl/sfr_checker.sv
// Port-level checks of the find/replace stream unit, bound to its top level.
// Depends on assert_macros.svh and sfr_pkg for field widths.
`include "assert_macros.svh"

module sfr_checker import sfr_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              res_valid,
	input logic              res_ready,
	input logic [BYTE_W-1:0] out_byte,
	input logic              out_valid,
	input logic              line_done,
	input logic [CNT_W-1:0]  repl_count,
	input logic              last_of_item
);

	// No new item while an unfinished item still has results in flight
	`ASSERT_CLK(a_busy_blocks_input, clk, arst_n, res_valid && !last_of_item |-> !in_ready)

	// A result without a byte is only the end-of-line marker
	`ASSERT_CLK(a_empty_is_marker, clk, arst_n, res_valid && !out_valid |-> line_done && out_byte == '0)

	// Count shows only on the line's final result
	`ASSERT_NEVER(a_count_off_line, clk, arst_n, res_valid && !line_done && repl_count != '0)

	// Line end always closes the item
	`ASSERT_CLK(a_done_is_last, clk, arst_n, res_valid && line_done |-> last_of_item)

	// Stalled result holds
	`ASSERT_CLK(a_hold_stalled, clk, arst_n, res_valid && !res_ready |=> res_valid && $stable(out_byte))

endmodule

bind string_find_replace_stream_unit sfr_checker u_sfr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (din.ready),
	.res_valid    (dout.valid),
	.res_ready    (dout.ready),
	.out_byte     (dout.out_byte),
	.out_valid    (dout.out_valid),
	.line_done    (dout.line_done),
	.repl_count   (dout.repl_count),
	.last_of_item (dout.last_of_item)
);
